/* rtl/assert_macros.svh */
// Assertion macros used by the generator top level.
// Each macro is clocked on the given clock and held off while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/arpg_pkg.sv */
// Types and constants for the autoregressive process generator.
// Used by the channel interfaces, the register block, the MAC, divider and top level.
package arpg_pkg;

    // Field widths
    localparam int ORDER_W  = 3;
    localparam int SAMPLE_W = 32;
    localparam int COEF_W   = 16;
    localparam int GAIN_W   = 16;
    localparam int DRAW_W   = 7;
    localparam int NUM_COEF = 4;

    // APB port
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // Datapath widths
    localparam int NOISE_W  = DRAW_W + 1 + GAIN_W + 1;   // (draw - 50) * gain
    localparam int MUL_W    = COEF_W + SAMPLE_W;         // one tap product
    localparam int ACC_W    = MUL_W + 2;                 // sum of up to four taps
    localparam int X_W      = ACC_W + 8;                 // taps * 100 + noise << 20
    localparam int ROUND_SHIFT = 14;                     // 409600 = 25 << 14
    localparam int DVD_FULL_W  = X_W - ROUND_SHIFT;
    localparam int DVD_W       = 36;                     // dividend below saturation

    // Scaling constants
    localparam int DRAW_BIAS   = 50;
    localparam int SCALE       = 100;
    localparam int NOISE_SHIFT = 20;
    localparam int ROUND_HALF  = 204800;
    localparam logic [DVD_FULL_W-1:0] SAT_LIMIT = DVD_FULL_W'(64'd53687091200); // 25 << 31
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 32'h7FFF_FFFF;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 32'h8000_0000;

    // Radix-16 divide by 25
    localparam int DIV_K       = 25;
    localparam int DIV_RECIP   = 41;                     // 41 / 1024 ~ 1 / 25
    localparam int RECIP_SHIFT = 10;
    localparam int DIGIT_W     = 4;
    localparam int REM_W       = 5;
    localparam int STEP_W      = REM_W + DIGIT_W;
    localparam int RPROD_W     = STEP_W + 6;
    localparam int DIV_STEPS   = DVD_W / DIGIT_W;

    // Register map index
    typedef enum logic [2:0] {
        REG_ORDER = 3'd0,
        REG_SEED  = 3'd1,
        REG_GAIN  = 3'd2,
        REG_COEF0 = 3'd3,
        REG_COEF1 = 3'd4,
        REG_COEF2 = 3'd5,
        REG_COEF3 = 3'd6
    } arpg_reg_t;

    // Configuration seen by the datapath
    typedef struct packed {
        logic [ORDER_W-1:0]                  order;
        logic [SAMPLE_W-1:0]                 seed;
        logic [GAIN_W-1:0]                   gain;
        logic [NUM_COEF-1:0][COEF_W-1:0]     coef;
    } arpg_cfg_t;

endpackage

/* rtl/arpg_if.sv */
// Valid/ready channel interfaces for the generator: input items and result items.
// Depends on arpg_pkg for the field widths.
interface arpg_in_if;
    logic                        valid;
    logic                        ready;
    logic [arpg_pkg::DRAW_W-1:0] uniform_draw;
    logic                        restart;

    modport source (output valid, output uniform_draw, output restart, input ready);
    modport sink   (input valid, input uniform_draw, input restart, output ready);
endinterface

interface arpg_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [arpg_pkg::SAMPLE_W-1:0] sample;
    logic                                 is_seed;

    modport source (output valid, output sample, output is_seed, input ready);
    modport sink   (input valid, input sample, input is_seed, output ready);
endinterface

/* rtl/arpg_regs.sv */
// APB register block for the generator: order, seed, noise gain and four coefficients.
// Depends on arpg_pkg for the register map and the configuration struct.
module arpg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [arpg_pkg::ADDR_W-1:0]   paddr,
    input  logic [arpg_pkg::DATA_W-1:0]   pwdata,
    output logic [arpg_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output arpg_pkg::arpg_cfg_t           cfg
);
    import arpg_pkg::*;

    // Order one tap, everything else zero
    localparam arpg_cfg_t CFG_RESET = '{order: ORDER_W'(1), seed: '0, gain: '0, coef: '0};

    arpg_cfg_t   cfg_reg;
    arpg_cfg_t   cfg_next;
    logic        wr_en;
    logic [2:0]  reg_idx;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    // Decode the write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_ORDER: cfg_next.order   = pwdata[ORDER_W-1:0];
                REG_SEED:  cfg_next.seed    = pwdata[SAMPLE_W-1:0];
                REG_GAIN:  cfg_next.gain    = pwdata[GAIN_W-1:0];
                REG_COEF0: cfg_next.coef[0] = pwdata[COEF_W-1:0];
                REG_COEF1: cfg_next.coef[1] = pwdata[COEF_W-1:0];
                REG_COEF2: cfg_next.coef[2] = pwdata[COEF_W-1:0];
                REG_COEF3: cfg_next.coef[3] = pwdata[COEF_W-1:0];
                default:   cfg_next = cfg_reg;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        unique case (reg_idx)
            REG_ORDER: prdata = DATA_W'(cfg_reg.order);
            REG_SEED:  prdata = DATA_W'(cfg_reg.seed);
            REG_GAIN:  prdata = DATA_W'(cfg_reg.gain);
            REG_COEF0: prdata = DATA_W'(cfg_reg.coef[0]);
            REG_COEF1: prdata = DATA_W'(cfg_reg.coef[1]);
            REG_COEF2: prdata = DATA_W'(cfg_reg.coef[2]);
            REG_COEF3: prdata = DATA_W'(cfg_reg.coef[3]);
            default:   prdata = '0;
        endcase
    end

    // Hold the registers; order resets to one tap
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* rtl/arpg_mac.sv */
// Shared multiply-accumulate unit: one coefficient times one past sample per cycle.
// Product is registered before the accumulate. Depends on arpg_pkg.
module arpg_mac (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                clr,
    input  logic                                en,
    input  logic signed [arpg_pkg::COEF_W-1:0]  coef,
    input  logic signed [arpg_pkg::SAMPLE_W-1:0] hist,
    output logic signed [arpg_pkg::ACC_W-1:0]   acc
);
    import arpg_pkg::*;

    logic signed [MUL_W-1:0] prod_reg;
    logic signed [MUL_W-1:0] prod_next;
    logic                    prod_vld_reg;
    logic                    prod_vld_next;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;

    assign acc = acc_reg;

    // Multiply, then add the previous product
    always_comb
    begin
        prod_next     = MUL_W'(coef) * MUL_W'(hist);
        prod_vld_next = en && !clr;
        if (clr)
            acc_next = '0;
        else if (prod_vld_reg)
            acc_next = acc_reg + ACC_W'(prod_reg);
        else
            acc_next = acc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_reg     <= '0;
            prod_vld_reg <= 1'b0;
            acc_reg      <= '0;
        end
        else
        begin
            prod_reg     <= prod_next;
            prod_vld_reg <= prod_vld_next;
            acc_reg      <= acc_next;
        end
    end

endmodule

/* rtl/arpg_div25.sv */
// Digit-serial divider by 25: one radix-16 quotient digit per cycle.
// Digit comes from a reciprocal multiply; depends on arpg_pkg.
module arpg_div25 (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [arpg_pkg::DVD_W-1:0]       dividend,
    output logic                             done,
    output logic [arpg_pkg::SAMPLE_W-1:0]    quotient
);
    import arpg_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_STEPS - 1);

    logic                busy_reg,  busy_next;
    logic                done_reg,  done_next;
    logic [CNT_W-1:0]    cnt_reg,   cnt_next;
    logic [REM_W-1:0]    rem_reg,   rem_next;
    logic [DVD_W-1:0]    dvd_reg,   dvd_next;
    logic [DVD_W-1:0]    quo_reg,   quo_next;
    logic [STEP_W-1:0]   step_v;
    logic [RPROD_W-1:0]  recip_prod;
    logic [DIGIT_W-1:0]  digit;
    logic [STEP_W-1:0]   step_rem;

    assign done     = done_reg;
    assign quotient = quo_reg[SAMPLE_W-1:0];

    // One digit: bring in a nibble, estimate by 41/1024, take the remainder
    always_comb
    begin
        step_v     = {rem_reg, dvd_reg[DVD_W-1 -: DIGIT_W]};
        recip_prod = RPROD_W'(step_v) * RPROD_W'(DIV_RECIP);
        digit      = recip_prod[RECIP_SHIFT +: DIGIT_W];
        step_rem   = step_v - STEP_W'(digit) * STEP_W'(DIV_K);
    end

    // Sequence the steps
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dvd_next  = dividend;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = step_rem[REM_W-1:0];
            dvd_next = {dvd_reg[DVD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            quo_next = {quo_reg[DVD_W-DIGIT_W-1:0], digit};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            dvd_reg  <= '0;
            quo_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            rem_reg  <= rem_next;
            dvd_reg  <= dvd_next;
            quo_reg  <= quo_next;
        end
    end

endmodule

/* rtl/autoregressive_process_generator_top.sv */
// Autoregressive process generator, order up to MAX_ORDER, one sample per input beat.
// Depends on arpg_pkg, arpg_if, arpg_regs, arpg_mac, arpg_div25 and assert_macros.svh.
//
// Usage:
//   in_ch  : sink of input beats (uniform_draw, restart). ready is high only while idle.
//   out_ch : source of result beats (sample, is_seed), held in an output register.
//   APB    : registers at 4*i: order, seed, noise gain, coefficients zero to three.
//            Write only while no beat is in flight.
// Sequence:
//   Seed sample: S_OUT registers the seed once the output register is free.
//   Computed sample: the taps in turn through the shared multiply-accumulate unit,
//   a drain step, then scale, round and range check, then the radix-16 divide by
//   25 that removes the fixed-point scale, and S_OUT registers the result. With no
//   taps the multiply-accumulate and drain steps are skipped. A saturated result
//   skips the divide and goes from the range check straight to S_OUT.
//   A new input beat can be taken in the cycle after the result is registered.
// Reset clears the history to zero, the seed count, and the output valid; the
// registers return to order one with all other values zero.
// A stalled receiver holds the result in the output register; the next item may be
// taken and computed, but it waits to be registered until the earlier beat leaves.
module autoregressive_process_generator_top #(
    parameter int MAX_ORDER = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [arpg_pkg::ADDR_W-1:0]   paddr,
    input  logic [arpg_pkg::DATA_W-1:0]   pwdata,
    output logic [arpg_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    arpg_in_if.sink                       in_ch,
    arpg_out_if.source                    out_ch
);
    import arpg_pkg::*;
    `include "assert_macros.svh"

    localparam logic [ORDER_W-1:0] MAX_ORD = ORDER_W'(MAX_ORDER);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC,
        S_DRAIN,
        S_SCALE,
        S_ROUND,
        S_CHECK,
        S_DIV,
        S_OUT
    } state_t;

    arpg_cfg_t cfg;

    state_t                  state_reg,      state_next;
    logic [SAMPLE_W-1:0]     hist_reg  [MAX_ORDER];
    logic [SAMPLE_W-1:0]     hist_next [MAX_ORDER];
    logic [ORDER_W-1:0]      seed_cnt_reg,   seed_cnt_next;
    logic [ORDER_W-1:0]      ord_reg,        ord_next;
    logic [ORDER_W-1:0]      tap_reg,        tap_next;
    logic signed [NOISE_W-1:0] noise_reg,    noise_next;
    logic signed [X_W-1:0]   x_reg,          x_next;
    logic [X_W-1:0]          mag_reg,        mag_next;
    logic                    neg_reg,        neg_next;
    logic [SAMPLE_W-1:0]     res_reg,        res_next;
    logic                    flag_reg,       flag_next;
    logic                    out_valid_reg,  out_valid_next;
    logic [SAMPLE_W-1:0]     out_sample_reg, out_sample_next;
    logic                    out_seed_reg,   out_seed_next;

    logic                    accept;
    logic [ORDER_W-1:0]      ord_clamp;
    logic [ORDER_W-1:0]      cnt_start;
    logic signed [DRAW_W:0]  draw_c;
    logic [SAMPLE_W-1:0]     hist_sel;
    logic [COEF_W-1:0]       coef_sel;
    logic                    mac_en;
    logic signed [ACC_W-1:0] mac_acc;
    logic [X_W-1:0]          x_abs;
    logic [DVD_FULL_W-1:0]   dvd_full;
    logic                    div_start;
    logic                    div_done;
    logic [SAMPLE_W-1:0]     div_q;

    arpg_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    arpg_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .clr   (accept),
        .en    (mac_en),
        .coef  ($signed(coef_sel)),
        .hist  ($signed(hist_sel)),
        .acc   (mac_acc)
    );

    arpg_div25 u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dvd_full[DVD_W-1:0]),
        .done     (div_done),
        .quotient (div_q)
    );

    // Channel outputs
    assign in_ch.ready    = (state_reg == S_IDLE);
    assign accept         = in_ch.valid && (state_reg == S_IDLE);
    assign out_ch.valid   = out_valid_reg;
    assign out_ch.sample  = $signed(out_sample_reg);
    assign out_ch.is_seed = out_seed_reg;

    // Front-end decode of the beat
    assign ord_clamp = (cfg.order > MAX_ORD) ? MAX_ORD : cfg.order;
    assign cnt_start = in_ch.restart ? '0 : seed_cnt_reg;
    assign draw_c    = $signed({1'b0, in_ch.uniform_draw}) - (DRAW_W + 1)'(DRAW_BIAS);
    assign mac_en    = (state_reg == S_MAC);
    assign x_abs     = x_reg[X_W-1] ? X_W'(-x_reg) : X_W'(x_reg);
    assign dvd_full  = mag_reg[X_W-1:ROUND_SHIFT];
    assign div_start = (state_reg == S_CHECK) && (dvd_full < SAT_LIMIT);

    // Select the tap operands
    always_comb
    begin
        hist_sel = '0;
        coef_sel = '0;
        for (int k = 0; k < MAX_ORDER; k++)
        begin
            if (tap_reg == ORDER_W'(k))
            begin
                hist_sel = hist_reg[k];
                coef_sel = cfg.coef[k];
            end
        end
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        hist_next       = hist_reg;
        seed_cnt_next   = seed_cnt_reg;
        ord_next        = ord_reg;
        tap_next        = tap_reg;
        noise_next      = noise_reg;
        x_next          = x_reg;
        mag_next        = mag_reg;
        neg_next        = neg_reg;
        res_next        = res_reg;
        flag_next       = flag_reg;
        out_valid_next  = out_valid_reg;
        out_sample_next = out_sample_reg;
        out_seed_next   = out_seed_reg;

        // Drop the result once taken
        if (out_valid_reg && out_ch.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (cnt_start < ord_clamp)
                    begin
                        res_next      = cfg.seed;
                        flag_next     = 1'b1;
                        seed_cnt_next = cnt_start + ORDER_W'(1);
                        state_next    = S_OUT;
                    end
                    else
                    begin
                        flag_next     = 1'b0;
                        seed_cnt_next = cnt_start;
                        ord_next      = ord_clamp;
                        tap_next      = '0;
                        noise_next    = NOISE_W'(draw_c) * NOISE_W'($signed({1'b0, cfg.gain}));
                        state_next    = (ord_clamp == '0) ? S_SCALE : S_MAC;
                    end
                end
            end
            S_MAC:
            begin
                tap_next = tap_reg + ORDER_W'(1);
                if (tap_reg == ord_reg - ORDER_W'(1))
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                x_next     = X_W'(mac_acc) * X_W'(SCALE) + (X_W'(noise_reg) <<< NOISE_SHIFT);
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                mag_next   = x_abs + X_W'(ROUND_HALF);
                neg_next   = x_reg[X_W-1];
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (dvd_full < SAT_LIMIT)
                begin
                    state_next = S_DIV;
                end
                else
                begin
                    res_next   = neg_reg ? SAMPLE_MIN : SAMPLE_MAX;
                    state_next = S_OUT;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    res_next   = neg_reg ? -div_q : div_q;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                // Register the result once the slot is free, and advance the history
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_sample_next = res_reg;
                    out_seed_next   = flag_reg;
                    hist_next[0]    = res_reg;
                    for (int k = 1; k < MAX_ORDER; k++)
                        hist_next[k] = hist_reg[k-1];
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            for (int k = 0; k < MAX_ORDER; k++)
                hist_reg[k] <= '0;
            seed_cnt_reg   <= '0;
            ord_reg        <= '0;
            tap_reg        <= '0;
            noise_reg      <= '0;
            x_reg          <= '0;
            mag_reg        <= '0;
            neg_reg        <= 1'b0;
            res_reg        <= '0;
            flag_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_sample_reg <= '0;
            out_seed_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            hist_reg       <= hist_next;
            seed_cnt_reg   <= seed_cnt_next;
            ord_reg        <= ord_next;
            tap_reg        <= tap_next;
            noise_reg      <= noise_next;
            x_reg          <= x_next;
            mag_reg        <= mag_next;
            neg_reg        <= neg_next;
            res_reg        <= res_next;
            flag_reg       <= flag_next;
            out_valid_reg  <= out_valid_next;
            out_sample_reg <= out_sample_next;
            out_seed_reg   <= out_seed_next;
        end
    end

    `ASSERT_NEXT(a_busy_after_beat, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready, "input taken while a beat is in flight")
    `ASSERT_IMPLY(a_div_done_in_div, clk, rst_n, div_done, state_reg == S_DIV, "divider finished outside the divide step")
    `ASSERT_ALWAYS(a_seed_cnt_range, clk, rst_n, seed_cnt_reg <= MAX_ORD, "seed count above the tap limit")

endmodule

/* verif/tb_autoregressive_process_generator_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the autoregressive process generator top level.
// Depends on arpg_pkg, the arpg_in_if / arpg_out_if channel interfaces and the RTL top.
module tb_autoregressive_process_generator_top;
    import arpg_pkg::*;

    localparam int     MAX_ORDER     = 4;
    localparam longint QUANT_DIV     = 409600;       // Q.28 * 100 down to Q.16
    localparam longint SAT_HI        = 64'sh7FFF_FFFF;
    localparam longint SAT_LO        = -SAT_HI - 1;
    localparam int     SETTLE_CYCLES = 24;           // longest compute plus margin
    localparam int     HOLD_CYCLES   = 300;          // long receiver hold-off
    localparam int     STALL_LIMIT   = 2000;         // cycles with no beat at all
    localparam int     PHASE_BEATS   = 150;
    localparam int     NUM_PHASES    = 12;

    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       is_seed;
    } sample_beat_t;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    arpg_in_if  in_ch ();
    arpg_out_if out_ch ();

    autoregressive_process_generator_top #(
        .MAX_ORDER (MAX_ORDER)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    // Mirror of the generator's registers and state
    logic [ORDER_W-1:0]         cfg_order;
    logic signed [SAMPLE_W-1:0] cfg_seed;
    logic [GAIN_W-1:0]          cfg_gain;
    logic signed [COEF_W-1:0]   cfg_coef [NUM_COEF];
    logic signed [SAMPLE_W-1:0] hist_q [MAX_ORDER];
    logic [ORDER_W-1:0]         seeds_emitted;

    sample_beat_t pending_samples [$];
    int           err_count;
    bit           no_gaps;
    bit           hold_req;

    // Clock: 10 ns period
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Work out the next sample and advance the mirrored history
    function automatic sample_beat_t predict_sample(input logic [DRAW_W-1:0] draw,
                                                    input logic restart);
        sample_beat_t beat;
        int           taps_used;
        longint       taps;
        longint       noise;
        longint       scaled;
        longint       mag;
        longint       q;
        taps_used = (cfg_order > MAX_ORDER) ? MAX_ORDER : int'(cfg_order);
        if (restart)
            seeds_emitted = '0;
        if (seeds_emitted < taps_used)
        begin
            beat.sample   = cfg_seed;
            beat.is_seed  = 1'b1;
            seeds_emitted = seeds_emitted + 1'b1;
        end
        else
        begin
            taps = 0;
            for (int j = 0; j < taps_used; j++)
                taps += longint'(cfg_coef[j]) * longint'(hist_q[j]);
            noise  = (longint'(draw) - DRAW_BIAS) * longint'(cfg_gain);
            scaled = taps * SCALE + noise * (longint'(1) << NOISE_SHIFT);
            mag    = (scaled < 0) ? -scaled : scaled;
            // Round half away from zero, then clamp to the sample range
            q = (mag + ROUND_HALF) / QUANT_DIV;
            if (scaled < 0)
                q = -q;
            if (q > SAT_HI)
                q = SAT_HI;
            if (q < SAT_LO)
                q = SAT_LO;
            beat.sample  = q[SAMPLE_W-1:0];
            beat.is_seed = 1'b0;
        end
        for (int k = MAX_ORDER - 1; k > 0; k--)
            hist_q[k] = hist_q[k-1];
        hist_q[0] = beat.sample;
        return beat;
    endfunction

    // APB write: setup cycle, access cycle, then drop the select
    task automatic reg_write(input arpg_reg_t idx, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(4 * int'(idx));
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_ORDER: cfg_order = data[ORDER_W-1:0];
            REG_SEED:  cfg_seed  = data[SAMPLE_W-1:0];
            REG_GAIN:  cfg_gain  = data[GAIN_W-1:0];
            default:   cfg_coef[int'(idx) - int'(REG_COEF0)] = data[COEF_W-1:0];
        endcase
    endtask

    task automatic load_config(input logic [DATA_W-1:0] order, input logic [DATA_W-1:0] seed,
                               input logic [DATA_W-1:0] gain, input logic [DATA_W-1:0] c0,
                               input logic [DATA_W-1:0] c1, input logic [DATA_W-1:0] c2,
                               input logic [DATA_W-1:0] c3);
        reg_write(REG_ORDER, order);
        reg_write(REG_SEED, seed);
        reg_write(REG_GAIN, gain);
        reg_write(REG_COEF0, c0);
        reg_write(REG_COEF1, c1);
        reg_write(REG_COEF2, c2);
        reg_write(REG_COEF3, c3);
    endtask

    // Offer one input beat after a random gap and record its expected sample
    task automatic send_draw(input logic [DRAW_W-1:0] draw, input logic restart);
        int           gap;
        sample_beat_t exp_beat;
        gap = no_gaps ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.uniform_draw <= draw;
        in_ch.restart      <= restart;
        do
            @(posedge clk);
        while (!in_ch.ready);
        exp_beat = predict_sample(draw, restart);
        pending_samples.insert(pending_samples.size(), exp_beat);
    endtask

    // Drop valid, drain every expected sample and let the pipeline settle
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (pending_samples.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Reset state acts as a fresh sequence at order one
    task automatic test_reset_state();
        send_draw(7'd0, 1'b0);
        send_draw(7'd99, 1'b0);
        wait_idle();
    endtask

    // Four seeds at the top of the range, then positive saturation
    task automatic test_positive_saturation();
        load_config(32'd4, 32'h7FFF_FFFF, 32'h0000_FFFF, 32'h0000_7FFF, 32'h0000_7FFF,
                    32'h0000_7FFF, 32'h0000_7FFF);
        send_draw(7'd127, 1'b1);
        send_draw(7'd0, 1'b0);
        send_draw(7'd50, 1'b0);
        send_draw(7'd99, 1'b0);
        send_draw(7'd127, 1'b0);
        wait_idle();
    endtask

    // Most negative seed and weights: the product flips to a huge positive sum
    task automatic test_negative_saturation();
        load_config(32'd4, 32'h8000_0000, 32'd0, 32'h0000_8000, 32'h0000_8000,
                    32'h0000_8000, 32'h0000_8000);
        send_draw(7'd0, 1'b1);
        send_draw(7'd0, 1'b0);
        send_draw(7'd0, 1'b0);
        send_draw(7'd0, 1'b0);
        send_draw(7'd0, 1'b0);
        wait_idle();
    endtask

    // No taps: every sample is the noise term alone, restart has no seeds to make
    task automatic test_order_zero();
        load_config(32'd0, 32'h1234_5678, 32'h0000_FFFF, 32'h0000_1000, 32'd0, 32'd0, 32'd0);
        send_draw(7'd0, 1'b1);
        send_draw(7'd50, 1'b0);
        send_draw(7'd99, 1'b0);
        send_draw(7'd127, 1'b0);
        wait_idle();
    endtask

    // Order above the maximum clamps; raising the order mid-sequence resumes seeding
    task automatic test_order_change();
        load_config(32'd7, 32'h0001_0000, 32'h0000_0100, 32'h0000_1000, 32'h0000_F000,
                    32'h0000_0800, 32'h0000_0001);
        send_draw(7'd10, 1'b1);
        send_draw(7'd20, 1'b0);
        send_draw(7'd30, 1'b0);
        send_draw(7'd40, 1'b0);
        send_draw(7'd77, 1'b0);
        wait_idle();
        reg_write(REG_ORDER, 32'd2);
        send_draw(7'd60, 1'b1);
        send_draw(7'd70, 1'b0);
        wait_idle();
        reg_write(REG_ORDER, 32'd4);
        send_draw(7'd80, 1'b0);
        send_draw(7'd90, 1'b0);
        send_draw(7'd5, 1'b0);
        wait_idle();
    endtask

    // Hold the receiver off for a long stretch while the sender keeps offering beats
    task automatic test_output_stall();
        int n;
        load_config(32'd2, 32'h0001_8000, 32'h0000_0040, 32'h0000_0C00, 32'h0000_FC00,
                    32'd0, 32'd0);
        hold_req = 1'b1;
        for (n = 0; n < 24; n++)
            send_draw(7'($urandom_range(0, 99)), n == 0);
        wait_idle();
    endtask

    // Phases of settings, two fixed extremes then random, each with random sequences
    task automatic test_random_sequences();
        int                ph;
        int                n;
        int                j;
        logic [DATA_W-1:0] tmp;
        logic [DATA_W-1:0] c [NUM_COEF];
        logic [DATA_W-1:0] ord_w;
        logic [DATA_W-1:0] seed_w;
        logic [DATA_W-1:0] gain_w;
        logic [DRAW_W-1:0] draw;
        logic              rst_seq;
        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            no_gaps = (ph % 4 == 3);
            if (ph == 0)
            begin
                ord_w  = 32'd4;
                seed_w = 32'h7FFF_FFFF;
                gain_w = 32'h0000_FFFF;
                for (j = 0; j < NUM_COEF; j++)
                    c[j] = 32'h0000_7FFF;
            end
            else if (ph == 1)
            begin
                ord_w  = 32'd7;
                seed_w = 32'h8000_0000;
                gain_w = 32'd0;
                for (j = 0; j < NUM_COEF; j++)
                    c[j] = 32'h0000_8000;
            end
            else
            begin
                // Upper bits of each write are junk the block must ignore
                ord_w  = $urandom;
                seed_w = $urandom;
                gain_w = $urandom;
                for (j = 0; j < NUM_COEF; j++)
                begin
                    tmp = $urandom;
                    if (ph % 3 == 2)
                        c[j] = tmp;
                    else
                        c[j] = {tmp[31:16], 16'($urandom_range(0, 2048) - 1024)};
                end
            end
            load_config(ord_w, seed_w, gain_w, c[0], c[1], c[2], c[3]);
            for (n = 0; n < PHASE_BEATS; n++)
            begin
                rst_seq = (n == 0) || ($urandom_range(0, 39) == 0);
                if ($urandom_range(0, 7) == 0)
                    draw = 7'($urandom_range(0, 127));
                else
                    draw = 7'($urandom_range(0, 99));
                send_draw(draw, rst_seq);
            end
            wait_idle();
        end
        no_gaps = 1'b0;
    endtask

    // Result receiver: random stall per beat, one long hold-off on request
    initial
    begin : result_sink
        int stall;
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                stall    = HOLD_CYCLES;
            end
            else
                stall = no_gaps ? 0 : $urandom_range(0, 11);
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_ch.valid);
        end
    end

    // Compare each accepted result beat with the oldest expectation
    always @(posedge clk)
    begin : result_check
        sample_beat_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_samples.size() == 0)
            begin
                $error("unexpected result beat: sample %0d is_seed %0b",
                       out_ch.sample, out_ch.is_seed);
                err_count++;
            end
            else
            begin
                want = pending_samples.pop_front();
                if (out_ch.sample !== want.sample)
                begin
                    $error("sample mismatch: expected %0d, actual %0d",
                           want.sample, out_ch.sample);
                    err_count++;
                end
                if (out_ch.is_seed !== want.is_seed)
                begin
                    $error("is_seed mismatch: expected %0b, actual %0b",
                           want.is_seed, out_ch.is_seed);
                    err_count++;
                end
            end
        end
    end

    // Watchdog: end the run once nothing has moved for too long
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                (psel && penable && pready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

    // Main sequence
    initial
    begin
        rst_n              <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        in_ch.valid        <= 1'b0;
        in_ch.uniform_draw <= '0;
        in_ch.restart      <= 1'b0;
        err_count = 0;
        no_gaps   = 1'b0;
        hold_req  = 1'b0;
        cfg_order = ORDER_W'(1);
        cfg_seed  = '0;
        cfg_gain  = '0;
        seeds_emitted = '0;
        for (int k = 0; k < NUM_COEF; k++)
            cfg_coef[k] = '0;
        for (int k = 0; k < MAX_ORDER; k++)
            hist_q[k] = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_positive_saturation();
        test_negative_saturation();
        test_order_zero();
        test_order_change();
        test_output_stall();
        test_random_sequences();

        if (err_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/arpg_pkg.sv
rtl/arpg_if.sv
rtl/arpg_regs.sv
rtl/arpg_mac.sv
rtl/arpg_div25.sv
rtl/autoregressive_process_generator_top.sv
verif/tb_autoregressive_process_generator_top.sv
